/* rtl/core/jtl_pkg.sv */
// jtl_pkg: shared constants for the JSON token lexer.
// Token codes, result kinds and default widths; no dependencies.
`timescale 1ns / 1ps

package jtl_pkg;

   localparam int TYPE_W = 4;
   localparam int BYTE_W = 8;

   localparam int ROW_BITS_DEFAULT    = 24;
   localparam int COLUMN_BITS_DEFAULT = 16;
   localparam int LENGTH_BITS_DEFAULT = 16;

   localparam logic KIND_RECORD  = 1'b0;
   localparam logic KIND_CONTENT = 1'b1;

   localparam logic [TYPE_W-1:0] T_INVALID   = 4'd0;
   localparam logic [TYPE_W-1:0] T_OBJ_OPEN  = 4'd1;
   localparam logic [TYPE_W-1:0] T_OBJ_CLOSE = 4'd2;
   localparam logic [TYPE_W-1:0] T_ARR_OPEN  = 4'd3;
   localparam logic [TYPE_W-1:0] T_ARR_CLOSE = 4'd4;
   localparam logic [TYPE_W-1:0] T_TRUE      = 4'd5;
   localparam logic [TYPE_W-1:0] T_FALSE     = 4'd6;
   localparam logic [TYPE_W-1:0] T_NULL      = 4'd7;
   localparam logic [TYPE_W-1:0] T_COLON     = 4'd8;
   localparam logic [TYPE_W-1:0] T_COMMA     = 4'd9;
   localparam logic [TYPE_W-1:0] T_STRING    = 4'd10;
   localparam logic [TYPE_W-1:0] T_INT       = 4'd11;
   localparam logic [TYPE_W-1:0] T_FLOAT     = 4'd12;
   localparam logic [TYPE_W-1:0] T_END       = 4'd13;

endpackage

/* rtl/core/json_token_lexer.sv */
// JSON token lexer. Takes one byte of JSON text per transfer (or an end-of-input
// marker) and returns token records and string/number content bytes, each
// tagged with the row and column where its token starts. A byte is registered
// on input and processed in the next cycle by single-pass logic that updates
// the lexer state; its zero, one or two results enter a three-entry result
// queue, so the first result of a byte passes through the input register and
// the queue before it can leave. A byte is taken every cycle while the queue
// has room for its results. A byte with two results (a number or keyword ended
// by punctuation or by the first byte of a number, or end of input that closes
// a token) needs two transfers on the single result port, so a steady run of such
// bytes fills the queue, and then result stalls back up into input stalls.
// Depends on jtl_pkg, jtl_engine and jtl_result_queue.
`timescale 1ns / 1ps

module json_token_lexer #(
   parameter int ROW_BITS    = jtl_pkg::ROW_BITS_DEFAULT,
   parameter int COLUMN_BITS = jtl_pkg::COLUMN_BITS_DEFAULT,
   parameter int LENGTH_BITS = jtl_pkg::LENGTH_BITS_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [jtl_pkg::BYTE_W-1:0]  req_data_byte,
   input  logic                        req_end_of_input,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic                        rsp_result_kind,
   output logic [jtl_pkg::TYPE_W-1:0]  rsp_token_code,
   output logic [jtl_pkg::BYTE_W-1:0]  rsp_content_byte,
   output logic [LENGTH_BITS-1:0]      rsp_content_length,
   output logic [ROW_BITS-1:0]         rsp_start_row,
   output logic [COLUMN_BITS-1:0]      rsp_start_column,
   output logic                        rsp_last_of_run
);

   localparam int RES_W = 1 + jtl_pkg::TYPE_W + jtl_pkg::BYTE_W + LENGTH_BITS
                          + ROW_BITS + COLUMN_BITS + 1;

   typedef struct packed {
      logic                       kind;
      logic [jtl_pkg::TYPE_W-1:0] ttype;
      logic [jtl_pkg::BYTE_W-1:0] data;
      logic [LENGTH_BITS-1:0]     len;
      logic [ROW_BITS-1:0]        row;
      logic [COLUMN_BITS-1:0]     col;
      logic                       last;
   } res_type;

   logic                       in_valid_ff;
   logic [jtl_pkg::BYTE_W-1:0] in_byte_ff;
   logic                       in_eoi_ff;

   logic [1:0]       res_count;
   logic [RES_W-1:0] res0, res1, head_bits;
   logic [1:0]       room;
   logic             commit, pop;
   res_type          head;

   assign commit    = in_valid_ff && (res_count <= room);
   assign req_stall = in_valid_ff && !commit;
   assign pop       = rsp_valid && !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_byte_ff <= req_data_byte;
         in_eoi_ff  <= req_end_of_input;
      end
   end

   jtl_engine #(
      .ROW_BITS    (ROW_BITS),
      .COLUMN_BITS (COLUMN_BITS),
      .LENGTH_BITS (LENGTH_BITS)
   ) u_engine (
      .clock        (clock),
      .reset        (reset),
      .commit       (commit),
      .data_byte    (in_byte_ff),
      .end_of_input (in_eoi_ff),
      .res_count    (res_count),
      .res0         (res0),
      .res1         (res1)
   );

   jtl_result_queue #(
      .WIDTH (RES_W)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_count (commit ? res_count : 2'd0),
      .push0      (res0),
      .push1      (res1),
      .pop        (pop),
      .room       (room),
      .head_valid (rsp_valid),
      .head       (head_bits)
   );

   assign head               = head_bits;
   assign rsp_result_kind    = head.kind;
   assign rsp_token_code     = head.ttype;
   assign rsp_content_byte   = head.data;
   assign rsp_content_length = head.len;
   assign rsp_start_row      = head.row;
   assign rsp_start_column   = head.col;
   assign rsp_last_of_run    = head.last;

`ifndef SYNTHESIS
   a_content_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_result_kind == jtl_pkg::KIND_CONTENT) |-> rsp_last_of_run)
      else $error("content result not flagged last of run");

   a_end_token_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_token_code == jtl_pkg::T_END)
      |-> rsp_last_of_run && (rsp_result_kind == jtl_pkg::KIND_RECORD))
      else $error("end token malformed");

   a_pair_reaches_output: assert property (@(posedge clock) disable iff (reset)
      commit && (res_count == 2'd2) |=> rsp_valid)
      else $error("committed result pair not visible");
`endif

endmodule

/* rtl/core/jtl_engine.sv */
// jtl_engine: lexer state registers and the per-byte next-state/result logic.
// Produces up to two results per item. Depends on jtl_pkg.
`timescale 1ns / 1ps

module jtl_engine #(
   parameter int ROW_BITS    = jtl_pkg::ROW_BITS_DEFAULT,
   parameter int COLUMN_BITS = jtl_pkg::COLUMN_BITS_DEFAULT,
   parameter int LENGTH_BITS = jtl_pkg::LENGTH_BITS_DEFAULT,
   localparam int RES_W = 1 + jtl_pkg::TYPE_W + jtl_pkg::BYTE_W + LENGTH_BITS
                          + ROW_BITS + COLUMN_BITS + 1
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        commit,
   input  logic [jtl_pkg::BYTE_W-1:0]  data_byte,
   input  logic                        end_of_input,
   output logic [1:0]                  res_count,
   output logic [RES_W-1:0]            res0,
   output logic [RES_W-1:0]            res1
);

   localparam logic [3:0] M_IDLE  = 4'd0;
   localparam logic [3:0] M_STR   = 4'd1;
   localparam logic [3:0] M_NSIGN = 4'd2;
   localparam logic [3:0] M_NINT  = 4'd3;
   localparam logic [3:0] M_NDOT  = 4'd4;
   localparam logic [3:0] M_NFRAC = 4'd5;
   localparam logic [3:0] M_NEXP  = 4'd6;
   localparam logic [3:0] M_NESIGN = 4'd7;
   localparam logic [3:0] M_NEDIG = 4'd8;
   localparam logic [3:0] M_WORD  = 4'd9;

   localparam logic [ROW_BITS-1:0]    ROW_MAX = {ROW_BITS{1'b1}};
   localparam logic [COLUMN_BITS-1:0] COL_MAX = {COLUMN_BITS{1'b1}};
   localparam logic [LENGTH_BITS-1:0] LEN_MAX = {LENGTH_BITS{1'b1}};

   typedef struct packed {
      logic                       kind;
      logic [jtl_pkg::TYPE_W-1:0] ttype;
      logic [jtl_pkg::BYTE_W-1:0] data;
      logic [LENGTH_BITS-1:0]     len;
      logic [ROW_BITS-1:0]        row;
      logic [COLUMN_BITS-1:0]     col;
      logic                       last;
   } res_type;

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= 8'h30) && (c <= 8'h39);
   endfunction

   function automatic logic is_alpha(input logic [7:0] c);
      return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
   endfunction

   function automatic logic is_space(input logic [7:0] c);
      return (c == 8'h20) || (c == 8'h0A) || (c == 8'h09) || (c == 8'h0D)
          || (c == 8'h0B);
   endfunction

   function automatic logic [jtl_pkg::TYPE_W-1:0] punct_token(input logic [7:0] c);
      logic [jtl_pkg::TYPE_W-1:0] t;
      t = jtl_pkg::T_INVALID;
      unique case (c)
         8'h7B:   t = jtl_pkg::T_OBJ_OPEN;
         8'h7D:   t = jtl_pkg::T_OBJ_CLOSE;
         8'h5B:   t = jtl_pkg::T_ARR_OPEN;
         8'h5D:   t = jtl_pkg::T_ARR_CLOSE;
         8'h3A:   t = jtl_pkg::T_COLON;
         8'h2C:   t = jtl_pkg::T_COMMA;
         default: t = jtl_pkg::T_INVALID;
      endcase
      return t;
   endfunction

   // keyword 0 "true", 1 "false", 2 "null"
   function automatic logic [7:0] kw_char(input logic [1:0] k, input logic [2:0] p);
      logic [7:0] ch;
      ch = 8'h00;
      unique case (k)
         2'd0: begin
            case (p)
               3'd0: ch = 8'h74;
               3'd1: ch = 8'h72;
               3'd2: ch = 8'h75;
               3'd3: ch = 8'h65;
               default: ch = 8'h00;
            endcase
         end
         2'd1: begin
            case (p)
               3'd0: ch = 8'h66;
               3'd1: ch = 8'h61;
               3'd2: ch = 8'h6C;
               3'd3: ch = 8'h73;
               3'd4: ch = 8'h65;
               default: ch = 8'h00;
            endcase
         end
         2'd2: begin
            case (p)
               3'd0: ch = 8'h6E;
               3'd1: ch = 8'h75;
               3'd2: ch = 8'h6C;
               3'd3: ch = 8'h6C;
               default: ch = 8'h00;
            endcase
         end
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

   function automatic logic [2:0] kw_len(input logic [1:0] k);
      return (k == 2'd1) ? 3'd5 : 3'd4;
   endfunction

   function automatic logic [jtl_pkg::TYPE_W-1:0] kw_token(input logic [1:0] k);
      logic [jtl_pkg::TYPE_W-1:0] t;
      unique case (k)
         2'd0:    t = jtl_pkg::T_TRUE;
         2'd1:    t = jtl_pkg::T_FALSE;
         2'd2:    t = jtl_pkg::T_NULL;
         default: t = jtl_pkg::T_INVALID;
      endcase
      return t;
   endfunction

   function automatic logic [2:0] word_keep(input logic [2:0] cand, input logic [2:0] prog,
                                            input logic [7:0] c);
      logic [2:0] keep;
      keep = 3'b000;
      for (int i = 0; i < 3; i++) begin
         keep[i] = cand[i] && (prog < kw_len(2'(i))) && (kw_char(2'(i), prog) == c);
      end
      return keep;
   endfunction

   function automatic logic [jtl_pkg::TYPE_W-1:0] word_type(input logic [2:0] cand,
                                                             input logic [2:0] prog);
      logic [jtl_pkg::TYPE_W-1:0] t;
      t = jtl_pkg::T_INVALID;
      for (int i = 2; i >= 0; i--) begin
         if (cand[i] && (prog == kw_len(2'(i)))) t = kw_token(2'(i));
      end
      return t;
   endfunction

   logic [3:0]             mode_ff, mode_in;
   logic [2:0]             kwp_ff, kwp_in;
   logic [2:0]             kwc_ff, kwc_in;
   logic [ROW_BITS-1:0]    trow_ff, trow_in;
   logic [COLUMN_BITS-1:0] tcol_ff, tcol_in;
   logic [LENGTH_BITS-1:0] tlen_ff, tlen_in;
   logic [ROW_BITS-1:0]    crow_ff, crow_in;
   logic [COLUMN_BITS-1:0] ccol_ff, ccol_in;

   logic [LENGTH_BITS-1:0] len_inc;
   logic                   a_v, b_v, again;
   res_type                a, b, r0, r1;

   assign len_inc = (tlen_ff == LEN_MAX) ? tlen_ff : tlen_ff + 1'b1;

   always_comb begin
      mode_in = mode_ff;
      kwp_in  = kwp_ff;
      kwc_in  = kwc_ff;
      trow_in = trow_ff;
      tcol_in = tcol_ff;
      tlen_in = tlen_ff;
      crow_in = crow_ff;
      ccol_in = ccol_ff;
      a_v     = 1'b0;
      b_v     = 1'b0;
      again   = 1'b0;
      a       = '0;
      b       = '0;
      a.row   = trow_ff;
      a.col   = tcol_ff;

      if (end_of_input) begin
         mode_in = M_IDLE;
         unique case (mode_ff)
            M_IDLE: ;
            M_NINT: begin
               a_v = 1'b1; a.ttype = jtl_pkg::T_INT; a.len = tlen_ff;
            end
            M_NFRAC, M_NEDIG: begin
               a_v = 1'b1; a.ttype = jtl_pkg::T_FLOAT; a.len = tlen_ff;
            end
            M_WORD: begin
               a_v = 1'b1; a.ttype = word_type(kwc_ff, kwp_ff);
            end
            default: begin
               a_v = 1'b1; a.ttype = jtl_pkg::T_INVALID;
            end
         endcase
         b_v     = 1'b1;
         b.ttype = jtl_pkg::T_END;
         b.row   = crow_ff;
         b.col   = ccol_ff;
      end else begin
         if (data_byte == 8'h0A) begin
            crow_in = (crow_ff == ROW_MAX) ? crow_ff : crow_ff + 1'b1;
            ccol_in = '0;
         end else if (ccol_ff != COL_MAX) begin
            ccol_in = ccol_ff + 1'b1;
         end

         // content bytes inside a token share these fields
         a.kind = jtl_pkg::KIND_CONTENT;
         a.data = data_byte;
         a.len  = len_inc;
         a.ttype = (mode_ff == M_STR) ? jtl_pkg::T_STRING : jtl_pkg::T_INT;

         unique case (mode_ff)
            M_STR: begin
               a_v = 1'b1;
               if (data_byte == 8'h22) begin
                  a = '{kind: jtl_pkg::KIND_RECORD, ttype: jtl_pkg::T_STRING, data: '0,
                        len: tlen_ff, row: trow_ff, col: tcol_ff, last: 1'b0};
                  mode_in = M_IDLE;
               end else if ((data_byte >= 8'h20) && (data_byte <= 8'h7E)) begin
                  tlen_in = len_inc;
               end else begin
                  a = '{kind: jtl_pkg::KIND_RECORD, ttype: jtl_pkg::T_INVALID, data: '0,
                        len: '0, row: trow_ff, col: tcol_ff, last: 1'b0};
                  mode_in = M_IDLE;
               end
            end
            M_NSIGN, M_NDOT, M_NESIGN: begin
               a_v = 1'b1;
               if (is_digit(data_byte)) begin
                  tlen_in = len_inc;
                  mode_in = (mode_ff == M_NSIGN) ? M_NINT
                          : (mode_ff == M_NDOT) ? M_NFRAC : M_NEDIG;
               end else begin
                  a = '{kind: jtl_pkg::KIND_RECORD, ttype: jtl_pkg::T_INVALID, data: '0,
                        len: '0, row: trow_ff, col: tcol_ff, last: 1'b0};
                  mode_in = M_IDLE;
               end
            end
            M_NINT, M_NFRAC: begin
               a_v = 1'b1;
               if (is_digit(data_byte)) begin
                  tlen_in = len_inc;
               end else if ((data_byte == 8'h2E) && (mode_ff == M_NINT)) begin
                  tlen_in = len_inc;
                  mode_in = M_NDOT;
               end else if ((data_byte == 8'h65) || (data_byte == 8'h45)) begin
                  tlen_in = len_inc;
                  mode_in = M_NEXP;
               end else begin
                  a = '{kind: jtl_pkg::KIND_RECORD,
                        ttype: (mode_ff == M_NINT) ? jtl_pkg::T_INT : jtl_pkg::T_FLOAT,
                        data: '0, len: tlen_ff, row: trow_ff, col: tcol_ff, last: 1'b0};
                  again = 1'b1;
               end
            end
            M_NEXP: begin
               a_v = 1'b1;
               if ((data_byte == 8'h2B) || (data_byte == 8'h2D)) begin
                  tlen_in = len_inc;
                  mode_in = M_NESIGN;
               end else if (is_digit(data_byte)) begin
                  tlen_in = len_inc;
                  mode_in = M_NEDIG;
               end else begin
                  a = '{kind: jtl_pkg::KIND_RECORD, ttype: jtl_pkg::T_INVALID, data: '0,
                        len: '0, row: trow_ff, col: tcol_ff, last: 1'b0};
                  mode_in = M_IDLE;
               end
            end
            M_NEDIG: begin
               a_v = 1'b1;
               if (is_digit(data_byte)) begin
                  tlen_in = len_inc;
               end else begin
                  a = '{kind: jtl_pkg::KIND_RECORD, ttype: jtl_pkg::T_FLOAT, data: '0,
                        len: tlen_ff, row: trow_ff, col: tcol_ff, last: 1'b0};
                  again = 1'b1;
               end
            end
            M_WORD: begin
               if (is_alpha(data_byte)) begin
                  kwc_in = word_keep(kwc_ff, kwp_ff, data_byte);
                  kwp_in = (kwp_ff == 3'd7) ? kwp_ff : kwp_ff + 1'b1;
               end else begin
                  a_v = 1'b1;
                  a = '{kind: jtl_pkg::KIND_RECORD, ttype: word_type(kwc_ff, kwp_ff),
                        data: '0, len: '0, row: trow_ff, col: tcol_ff, last: 1'b0};
                  again = 1'b1;
               end
            end
            default: again = 1'b1;
         endcase

         // a terminating or idle-mode byte that is not white space starts the next token
         if (again) begin
            mode_in = M_IDLE;
            if (!is_space(data_byte)) begin
               trow_in = crow_in;
               tcol_in = ccol_in;
               tlen_in = '0;
               b.row   = crow_in;
               b.col   = ccol_in;
               if (punct_token(data_byte) != jtl_pkg::T_INVALID) begin
                  b_v     = 1'b1;
                  b.ttype = punct_token(data_byte);
               end else if (data_byte == 8'h22) begin
                  mode_in = M_STR;
               end else if (is_digit(data_byte) || (data_byte == 8'h2D)) begin
                  mode_in = is_digit(data_byte) ? M_NINT : M_NSIGN;
                  tlen_in = LENGTH_BITS'(1);
                  b_v     = 1'b1;
                  b.kind  = jtl_pkg::KIND_CONTENT;
                  b.ttype = jtl_pkg::T_INT;
                  b.data  = data_byte;
                  b.len   = LENGTH_BITS'(1);
               end else begin
                  mode_in = M_WORD;
                  kwc_in  = word_keep(3'b111, 3'd0, data_byte);
                  kwp_in  = 3'd1;
               end
            end
         end
      end

      r0      = a_v ? a : b;
      r0.last = !(a_v && b_v);
      r1      = b;
      r1.last = 1'b1;
   end

   assign res_count = {1'b0, a_v} + {1'b0, b_v};
   assign res0      = r0;
   assign res1      = r1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= M_IDLE;
         kwp_ff  <= 3'd0;
         kwc_ff  <= 3'b111;
         trow_ff <= '0;
         tcol_ff <= '0;
         tlen_ff <= '0;
         crow_ff <= ROW_BITS'(1);
         ccol_ff <= '0;
      end else if (commit) begin
         mode_ff <= mode_in;
         kwp_ff  <= kwp_in;
         kwc_ff  <= kwc_in;
         trow_ff <= trow_in;
         tcol_ff <= tcol_in;
         tlen_ff <= tlen_in;
         crow_ff <= crow_in;
         ccol_ff <= ccol_in;
      end
   end

endmodule

/* rtl/core/jtl_result_queue.sv */
// jtl_result_queue: three-entry shifting result queue, two writes and one read
// per cycle. Generic payload width; no package dependencies.
`timescale 1ns / 1ps

module jtl_result_queue #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic [1:0]       push_count,
   input  logic [WIDTH-1:0] push0,
   input  logic [WIDTH-1:0] push1,
   input  logic             pop,
   output logic [1:0]       room,
   output logic             head_valid,
   output logic [WIDTH-1:0] head
);

   localparam int DEPTH = 3;

   logic [WIDTH-1:0] q_ff [DEPTH];
   logic [WIDTH-1:0] q_in [DEPTH];
   logic [WIDTH-1:0] shifted [DEPTH];
   logic [1:0]       cnt_ff, cnt_in, cnt_ap;

   assign cnt_ap     = cnt_ff - {1'b0, pop};
   assign room       = 2'(DEPTH) - cnt_ap;
   assign cnt_in     = cnt_ap + push_count;
   assign head_valid = (cnt_ff != 2'd0);
   assign head       = q_ff[0];

   assign shifted[0] = q_ff[1];
   assign shifted[1] = q_ff[2];
   assign shifted[2] = q_ff[2];

   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         if (2'(i) < cnt_ap) begin
            q_in[i] = pop ? shifted[i] : q_ff[i];
         end else if ((2'(i) == cnt_ap) && (push_count != 2'd0)) begin
            q_in[i] = push0;
         end else if ((2'(i) == cnt_ap + 2'd1) && (push_count == 2'd2)) begin
            q_in[i] = push1;
         end else begin
            q_in[i] = q_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < DEPTH; i++) begin
         q_ff[i] <= q_in[i];
      end
   end

endmodule
